>>> sv/ibrc_pkg.sv
`default_nettype none

package ibrc_pkg;

    // Default label length before the character index saturates
    localparam int MAX_LABEL_CHARS_DEF = 64;

    localparam int CLASS_W     = 5;
    localparam int COND_W      = 3;
    localparam int POS_W       = 6;
    localparam int DIR_W       = 2;
    localparam int COUNT_W     = 7;
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    // Result slots one character can fill at most
    localparam int MAX_PUSH    = 4;
    // Candidate results per character: cond 1, cond 2/5, cond 3/6, cond 4, verdict
    localparam int NUM_CAND    = 5;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Register index, taken from paddr[2]
    localparam logic REG_REPORT_LIMIT = 1'b0;
    localparam logic [COUNT_W-1:0] REPORT_LIMIT_RST = 7'd16;

    // Bidi classes, UAX9 order
    localparam logic [CLASS_W-1:0] CLS_L   = 5'd0;
    localparam logic [CLASS_W-1:0] CLS_R   = 5'd1;
    localparam logic [CLASS_W-1:0] CLS_AL  = 5'd2;
    localparam logic [CLASS_W-1:0] CLS_EN  = 5'd3;
    localparam logic [CLASS_W-1:0] CLS_ES  = 5'd4;
    localparam logic [CLASS_W-1:0] CLS_ET  = 5'd5;
    localparam logic [CLASS_W-1:0] CLS_AN  = 5'd6;
    localparam logic [CLASS_W-1:0] CLS_CS  = 5'd7;
    localparam logic [CLASS_W-1:0] CLS_NSM = 5'd8;
    localparam logic [CLASS_W-1:0] CLS_BN  = 5'd9;
    localparam logic [CLASS_W-1:0] CLS_ON  = 5'd13;

    localparam logic [31:0] RTL_ALLOWED =
        (32'd1 << CLS_R) | (32'd1 << CLS_AL) | (32'd1 << CLS_AN) | (32'd1 << CLS_EN) |
        (32'd1 << CLS_ES) | (32'd1 << CLS_CS) | (32'd1 << CLS_ET) | (32'd1 << CLS_ON) |
        (32'd1 << CLS_BN) | (32'd1 << CLS_NSM);
    localparam logic [31:0] LTR_ALLOWED =
        (32'd1 << CLS_L) | (32'd1 << CLS_EN) | (32'd1 << CLS_ES) | (32'd1 << CLS_CS) |
        (32'd1 << CLS_ET) | (32'd1 << CLS_ON) | (32'd1 << CLS_BN) | (32'd1 << CLS_NSM);
    localparam logic [31:0] RTL_END_OK =
        (32'd1 << CLS_R) | (32'd1 << CLS_AL) | (32'd1 << CLS_EN) | (32'd1 << CLS_AN);
    localparam logic [31:0] LTR_END_OK = (32'd1 << CLS_L) | (32'd1 << CLS_EN);

    // Label direction codes
    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LTR  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RTL  = 2'd2;

    // Condition codes
    localparam logic [COND_W-1:0] COND_VERDICT = 3'd0;
    localparam logic [COND_W-1:0] COND_FIRST   = 3'd1;
    localparam logic [COND_W-1:0] COND_RTL_SET = 3'd2;
    localparam logic [COND_W-1:0] COND_RTL_END = 3'd3;
    localparam logic [COND_W-1:0] COND_NUM_MIX = 3'd4;
    localparam logic [COND_W-1:0] COND_LTR_SET = 3'd5;
    localparam logic [COND_W-1:0] COND_LTR_END = 3'd6;

    typedef struct packed {
        logic [CLASS_W-1:0] char_class;
        logic               last_char;
    } char_item_t;

    typedef struct packed {
        logic [COND_W-1:0]  condition;
        logic [POS_W-1:0]   position;
        logic               label_valid;
        logic [DIR_W-1:0]   direction;
        logic [COUNT_W-1:0] report_count;
        logic               last_result;
    } result_item_t;

endpackage

`default_nettype wire

>>> sv/idna_bidi_rule_checker.sv
`default_nettype none

// IDNA bidi rule checker (RFC 5893). Feed the bidi class of each character of a label,
// one transaction per character, with last_char set on the final one. Each violation comes
// out as a report (condition 1..6, character position, direction), at most report_limit of
// them per label, and every label ends with one verdict transaction (condition 0,
// last_result 1) carrying validity, direction and the number of reports emitted. A
// character is taken every cycle: it is registered, then its results (up to four) are
// written at once into an 8-entry result queue that drains one transaction per cycle when
// m_ready is high; a character advances out of the input register only while the queue has
// four free entries, so labels with many violations run at the queue's drain rate of one
// result per cycle. Positions saturate at MAX_LABEL_CHARS-1 and are reported in 6 bits.
module idna_bidi_rule_checker #(
    parameter int MAX_LABEL_CHARS = ibrc_pkg::MAX_LABEL_CHARS_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  ibrc_pkg::char_item_t              s_item,
    output logic                              m_valid,
    input  wire                               m_ready,
    output ibrc_pkg::result_item_t            m_item,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [ibrc_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire [ibrc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ibrc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import ibrc_pkg::*;

    localparam int IDX_W = (MAX_LABEL_CHARS > 2) ? $clog2(MAX_LABEL_CHARS) : 1;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_LABEL_CHARS - 1);

    // Configuration
    logic [COUNT_W-1:0] limit_reg;

    // Input register
    logic       in_valid_reg;
    char_item_t in_item_reg;

    // Label state
    logic [DIR_W-1:0]   dir_reg, dir_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   first_en_reg, first_en_next;
    logic               en_seen_reg, en_seen_next;
    logic [IDX_W-1:0]   first_an_reg, first_an_next;
    logic               an_seen_reg, an_seen_next;
    logic [IDX_W-1:0]   strong_idx_reg, strong_idx_next;
    logic [CLASS_W-1:0] strong_cls_reg, strong_cls_next;
    logic               still_valid_reg, still_valid_next;
    logic [COUNT_W-1:0] reports_reg, reports_next;

    // Result queue
    result_item_t       queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    logic               process;
    logic               pop;
    logic [CLASS_W-1:0] cls;
    logic               is_first;
    logic               v_first, v_set, v_end, v_mix;
    logic [COUNT_W-1:0] cnt1, cnt2, cnt3;
    logic [IDX_W-1:0]   mix_idx;
    result_item_t       cand [NUM_CAND];
    logic [NUM_CAND-1:0] push;
    logic [QPTR_W-1:0]  offs [NUM_CAND];
    logic [QPTR_W-1:0]  n_push;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_REPORT_LIMIT);
    assign prdata    = (paddr[2] == REG_REPORT_LIMIT) ?
                       APB_DATA_W'(limit_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= REPORT_LIMIT_RST;
        end else if (cfg_write) begin
            limit_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // Advance the input register only when the queue can take a worst-case burst
    assign process = in_valid_reg && (count_reg <= QCNT_W'(QUEUE_DEPTH - MAX_PUSH));
    assign s_ready = !in_valid_reg || process;
    assign m_valid = (count_reg != '0);
    assign m_item  = queue_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    always_comb begin
        cls      = in_item_reg.char_class;
        is_first = (idx_reg == '0);

        dir_next = dir_reg;
        v_first  = 1'b0;
        if (is_first) begin
            if (cls == CLS_L) begin
                dir_next = DIR_LTR;
            end else if (cls == CLS_R || cls == CLS_AL) begin
                dir_next = DIR_RTL;
            end else begin
                v_first = 1'b1;
            end
        end

        en_seen_next  = en_seen_reg;
        first_en_next = first_en_reg;
        an_seen_next  = an_seen_reg;
        first_an_next = first_an_reg;
        v_set         = 1'b0;
        if (dir_next == DIR_RTL) begin
            if (cls == CLS_EN && !en_seen_reg) begin
                en_seen_next  = 1'b1;
                first_en_next = idx_reg;
            end else if (cls == CLS_AN && !an_seen_reg) begin
                an_seen_next  = 1'b1;
                first_an_next = idx_reg;
            end
            v_set = !RTL_ALLOWED[cls];
        end else if (dir_next == DIR_LTR) begin
            v_set = !LTR_ALLOWED[cls];
        end

        strong_idx_next = strong_idx_reg;
        strong_cls_next = strong_cls_reg;
        if (cls != CLS_NSM) begin
            strong_idx_next = idx_reg;
            strong_cls_next = cls;
        end

        v_end = 1'b0;
        v_mix = 1'b0;
        if (in_item_reg.last_char) begin
            if (dir_next == DIR_RTL) begin
                v_end = !RTL_END_OK[strong_cls_next];
                v_mix = en_seen_next && an_seen_next;
            end else if (dir_next == DIR_LTR) begin
                v_end = !LTR_END_OK[strong_cls_next];
            end
        end
        mix_idx = (first_en_next > first_an_next) ? first_en_next : first_an_next;

        // Reports go out in order until the limit is reached; drop the rest
        push[0] = v_first && (reports_reg < limit_reg);
        cnt1    = reports_reg + COUNT_W'(push[0]);
        push[1] = v_set && (cnt1 < limit_reg);
        cnt2    = cnt1 + COUNT_W'(push[1]);
        push[2] = v_end && (cnt2 < limit_reg);
        cnt3    = cnt2 + COUNT_W'(push[2]);
        push[3] = v_mix && (cnt3 < limit_reg);
        reports_next = cnt3 + COUNT_W'(push[3]);
        push[4] = in_item_reg.last_char;

        still_valid_next = still_valid_reg && !(v_first || v_set || v_end || v_mix);

        cand[0] = '{condition: COND_FIRST, position: POS_W'(idx_reg), label_valid: 1'b0,
                    direction: dir_next, report_count: '0, last_result: 1'b0};
        cand[1] = '{condition: (dir_next == DIR_RTL) ? COND_RTL_SET : COND_LTR_SET,
                    position: POS_W'(idx_reg), label_valid: 1'b0,
                    direction: dir_next, report_count: '0, last_result: 1'b0};
        cand[2] = '{condition: (dir_next == DIR_RTL) ? COND_RTL_END : COND_LTR_END,
                    position: POS_W'(strong_idx_next), label_valid: 1'b0,
                    direction: dir_next, report_count: '0, last_result: 1'b0};
        cand[3] = '{condition: COND_NUM_MIX, position: POS_W'(mix_idx), label_valid: 1'b0,
                    direction: dir_next, report_count: '0, last_result: 1'b0};
        cand[4] = '{condition: COND_VERDICT, position: '0, label_valid: still_valid_next,
                    direction: dir_next, report_count: reports_next, last_result: 1'b1};

        offs[0] = '0;
        for (int k = 1; k < NUM_CAND; k++) begin
            offs[k] = offs[k-1] + QPTR_W'(push[k-1]);
        end
        n_push = offs[NUM_CAND-1] + QPTR_W'(push[NUM_CAND-1]);

        if (in_item_reg.last_char) begin
            idx_next = '0;
        end else if (idx_reg < IDX_MAX) begin
            idx_next = idx_reg + 1'b1;
        end else begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg         <= DIR_NONE;
            idx_reg         <= '0;
            first_en_reg    <= '0;
            en_seen_reg     <= 1'b0;
            first_an_reg    <= '0;
            an_seen_reg     <= 1'b0;
            strong_idx_reg  <= '0;
            strong_cls_reg  <= '0;
            still_valid_reg <= 1'b1;
            reports_reg     <= '0;
        end else if (process) begin
            if (in_item_reg.last_char) begin
                // Label done: return to the clean state
                dir_reg         <= DIR_NONE;
                first_en_reg    <= '0;
                en_seen_reg     <= 1'b0;
                first_an_reg    <= '0;
                an_seen_reg     <= 1'b0;
                strong_idx_reg  <= '0;
                strong_cls_reg  <= '0;
                still_valid_reg <= 1'b1;
                reports_reg     <= '0;
            end else begin
                dir_reg         <= dir_next;
                first_en_reg    <= first_en_next;
                en_seen_reg     <= en_seen_next;
                first_an_reg    <= first_an_next;
                an_seen_reg     <= an_seen_next;
                strong_idx_reg  <= strong_idx_next;
                strong_cls_reg  <= strong_cls_next;
                still_valid_reg <= still_valid_next;
                reports_reg     <= reports_next;
            end
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            for (int k = 0; k < NUM_CAND; k++) begin
                if (push[k]) begin
                    queue_reg[wr_ptr_reg + offs[k]] <= cand[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (process) begin
                wr_ptr_reg <= wr_ptr_reg + n_push;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (process ? QCNT_W'(n_push) : '0) - QCNT_W'(pop);
        end
    end

endmodule

`default_nettype wire
